// ===== rtl/amsplat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amsplat_pkg
// Shared types, command codes and the 3x3 neighbor offset tables for the
// agent minimap splatter.
// ----------------------------------------------------------------------------
package amsplat_pkg;

  // Command codes carried in the input transaction
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PLOT  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Height limit in Q8: 0.1 rounds down to 25
  localparam logic signed [19:0] ZLimitQ8 = 20'sd25;

  // Index of the last neighbor in the 3x3 walk
  localparam logic [3:0] SplatLast = 4'd8;

  // Input transaction
  typedef struct packed {
    cmd_e               command;
    logic               active;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic [7:0]         profession;
    logic               last_in_frame;
    logic [7:0]         read_col;
    logic [7:0]         read_row;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic [7:0] cell_value;
    logic       frame_done;
  } out_item_t;

  // Decode flags handed to the sequencer
  typedef struct packed {
    logic plot_go;
    logic read_ok;
  } dec_flags_t;

  // Column offset of neighbor k, row-major over the 3x3 window
  function automatic logic signed [1:0] nb_dx(logic [3:0] k);
    logic signed [1:0] d;
    unique case (k)
      4'd0, 4'd3, 4'd6: d = -2'sd1;
      4'd1, 4'd4, 4'd7: d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  // Row offset of neighbor k
  function automatic logic signed [1:0] nb_dy(logic [3:0] k);
    logic signed [1:0] d;
    unique case (k)
      4'd0, 4'd1, 4'd2: d = -2'sd1;
      4'd3, 4'd4, 4'd5: d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/amsplat_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amsplat_mem
// Minimap storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module amsplat_mem #(
  parameter int unsigned AW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [2**AW];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/amsplat_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amsplat_decode
// Qualify a transaction: height and activity test, world to cell mapping
// with truncation toward zero, grid range checks for plots and reads.
// ----------------------------------------------------------------------------
module amsplat_decode #(
  parameter int unsigned GRID_SIZE = 256,
  parameter int unsigned CW        = 8
) (
  input  amsplat_pkg::in_item_t   item_i,
  output amsplat_pkg::dec_flags_t flags_o,
  output logic [CW-1:0]           col_o,
  output logic [CW-1:0]           row_o,
  output logic [CW-1:0]           rcol_o,
  output logic [CW-1:0]           rrow_o
);
  import amsplat_pkg::*;

  localparam logic [10:0] GridW = 11'(GRID_SIZE);

  logic [10:0] xc, yc, rc, rr;
  logic        x_ok, y_ok, z_ok;

  // Map world to cell; a small negative value truncates to cell 0
  always_comb begin
    xc = item_i.pos_x[19] ? 11'd0 : {2'b00, item_i.pos_x[18:10]};
    yc = item_i.pos_y[19] ? 11'd0 : {2'b00, item_i.pos_y[18:10]};
    x_ok = item_i.pos_x[19] ?
           ((&item_i.pos_x[19:10]) && (|item_i.pos_x[9:0])) : (xc < GridW);
    y_ok = item_i.pos_y[19] ?
           ((&item_i.pos_y[19:10]) && (|item_i.pos_y[9:0])) : (yc < GridW);
    z_ok = (item_i.pos_z <= ZLimitQ8);
  end

  // Read coordinates
  assign rc = {3'b000, item_i.read_col};
  assign rr = {3'b000, item_i.read_row};

  assign flags_o.plot_go = item_i.active && z_ok && x_ok && y_ok;
  assign flags_o.read_ok = (rc < GridW) && (rr < GridW);

  assign col_o  = xc[CW-1:0];
  assign row_o  = yc[CW-1:0];
  assign rcol_o = rc[CW-1:0];
  assign rrow_o = rr[CW-1:0];

endmodule
`default_nettype wire

// ===== rtl/agent_minimap_splatter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// agent_minimap_splatter_unit
// Byte minimap of GRID_SIZE x GRID_SIZE cells with clear, 3x3 plot and read.
// ----------------------------------------------------------------------------
// One transaction is worked at a time; the minimap memory has a single write
// port, which sets the cost of each command. A plot that lands in the grid
// steps through accept, nine neighbor slots on the write port and result; a
// skipped plot or unused command goes from accept to result; a read steps
// through accept with read issue, registered read data and result. A clear
// writes every memory word, 4**ceil(log2(GRID_SIZE)) words (65536 at the
// default size), before its result. After reset the same clearing pass runs
// before the first transaction is accepted. The result sits in an output
// register, so the next transaction is accepted while it waits.
// ----------------------------------------------------------------------------
module agent_minimap_splatter_unit #(
  parameter int unsigned GRID_SIZE = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  amsplat_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output amsplat_pkg::out_item_t out_data_o
);
  import amsplat_pkg::*;

  localparam int unsigned CW = $clog2(GRID_SIZE);
  localparam int unsigned AW = 2 * CW;
  localparam logic [CW:0] GridW = (CW+1)'(GRID_SIZE);

  typedef enum logic [2:0] {
    ST_BOOT,
    ST_CLEAR,
    ST_IDLE,
    ST_SPLAT,
    ST_READ,
    ST_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [3:0]      k_q, k_d;
  logic [CW-1:0]   col_q, col_d, row_q, row_d;
  logic [7:0]      colour_q, colour_d;
  out_item_t       res_q, res_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_data_q, out_data_d;

  dec_flags_t      flags;
  logic [CW-1:0]   dcol, drow, rcol, rrow;
  logic            accept, out_free;

  logic signed [1:0]    dx, dy;
  logic signed [CW+1:0] px, py;
  logic                 px_ok, py_ok;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata, mem_rdata;

  amsplat_decode #(
    .GRID_SIZE (GRID_SIZE),
    .CW        (CW)
  ) u_decode (
    .item_i  (in_data_i),
    .flags_o (flags),
    .col_o   (dcol),
    .row_o   (drow),
    .rcol_o  (rcol),
    .rrow_o  (rrow)
  );

  amsplat_mem #(
    .AW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Current neighbor cell and its clipping
  always_comb begin
    dx = nb_dx(k_q);
    dy = nb_dy(k_q);
    px = $signed({2'b00, col_q}) + $signed({{CW{dx[1]}}, dx});
    py = $signed({2'b00, row_q}) + $signed({{CW{dy[1]}}, dy});
    px_ok = !px[CW+1] && (px[CW:0] < GridW);
    py_ok = !py[CW+1] && (py[CW:0] < GridW);
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 8'd0;
    unique case (state_q)
      ST_BOOT, ST_CLEAR: mem_we = 1'b1;
      ST_SPLAT: begin
        mem_we    = px_ok && py_ok;
        mem_waddr = {py[CW-1:0], px[CW-1:0]};
        mem_wdata = colour_q;
      end
      default: mem_we = 1'b0;
    endcase
    mem_re    = accept && (in_data_i.command == CMD_READ) && flags.read_ok;
    mem_raddr = {rrow, rcol};
  end

  // Sequencer and output register next state
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    k_d         = k_q;
    col_d       = col_q;
    row_d       = row_q;
    colour_d    = colour_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_BOOT: begin
        clr_d = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = ST_DONE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res_d    = '0;
          col_d    = dcol;
          row_d    = drow;
          colour_d = in_data_i.profession;
          k_d      = 4'd0;
          clr_d    = '0;
          unique case (in_data_i.command)
            CMD_CLEAR: state_d = ST_CLEAR;
            CMD_PLOT: begin
              res_d.frame_done = in_data_i.last_in_frame;
              state_d = flags.plot_go ? ST_SPLAT : ST_DONE;
            end
            CMD_READ: state_d = flags.read_ok ? ST_READ : ST_DONE;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_SPLAT: begin
        k_d = k_q + 4'd1;
        if (k_q == SplatLast) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        res_d.cell_value = mem_rdata;
        state_d          = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state; reset starts the clearing pass with no result pending
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_BOOT;
      clr_q       <= '0;
      k_q         <= '0;
      col_q       <= '0;
      row_q       <= '0;
      colour_q    <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      k_q         <= k_d;
      col_q       <= col_d;
      row_q       <= row_d;
      colour_q    <= colour_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/amsplat_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amsplat_checker
// Port-level checks on the splatter: sequential acceptance, result origin,
// clearing pass after reset, result kind and output hold under stall.
// ----------------------------------------------------------------------------
module amsplat_checker (
  input wire                     clk_i,
  input wire                     rst_ni,
  input wire                     in_valid_i,
  input wire                     in_stall_o,
  input amsplat_pkg::in_item_t   in_data_i,
  input wire                     out_valid_o,
  input wire                     out_stall_i,
  input amsplat_pkg::out_item_t  out_data_o
);

  // One transaction in flight: an accept is followed by stall
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("transaction accepted while another was in flight");

  // A new result only appears when the input side was busy just before
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a transaction at work");

  // The clearing pass holds off input right after reset
  a_reset_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("input accepted before the clearing pass");

  // Read data and frame done never show together
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done |-> out_data_o.cell_value == 8'd0)
    else $error("result carries both cell data and frame done");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind agent_minimap_splatter_unit amsplat_checker u_amsplat_checker (.*);
`default_nettype wire

// ===== sim/agent_minimap_splatter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agent_minimap_splatter_unit_tb
// Self-checking bench for the minimap splatter: it keeps a byte-for-byte
// shadow of the 256x256 map and works out every result as each command is
// accepted. Directed tests cover the grid corners and edges, the height
// limit, inactive agents, off-grid centers, overwrites, the unused command
// and clear. A random phase then mixes plots, reads near recent plots, a
// few clears and raw noise. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module agent_minimap_splatter_unit_tb;
  import amsplat_pkg::*;

  localparam int MapDim       = 256;
  localparam int CellDiv      = 1024;
  localparam int HeightMaxQ8  = 25;
  localparam int RandomItems  = 700;
  localparam int IdleLimit    = 200000;
  localparam int TailCycles   = 30;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      agent_valid = 1'b0;
  logic      agent_stall;
  in_item_t  agent_item = '0;
  logic      map_valid;
  logic      map_stall = 1'b0;
  out_item_t map_result;

  // Shadow map and the results still owed by the block
  logic [7:0] map_model [0:MapDim*MapDim-1];
  out_item_t  expected_cells[$];
  logic [15:0] recent_centers[$];

  int err_cnt = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int n_plot = 0, n_landed = 0, n_read = 0, n_clear = 0, n_unused = 0;

  agent_minimap_splatter_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (agent_valid),
    .in_stall_o (agent_stall),
    .in_data_i  (agent_item),
    .out_valid_o(map_valid),
    .out_stall_i(map_stall),
    .out_data_o (map_result)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    foreach (map_model[i]) map_model[i] = '0;
  end

  // Update the shadow map for one command and return the result it owes
  function automatic out_item_t splat_predict(input in_item_t it);
    out_item_t r;
    int col, row, px, py;
    r = '0;
    case (it.command)
      CMD_CLEAR: begin
        foreach (map_model[i]) map_model[i] = '0;
      end
      CMD_PLOT: begin
        r.frame_done = it.last_in_frame;
        if (it.active && int'(it.pos_z) <= HeightMaxQ8) begin
          // signed int division truncates toward zero
          col = int'(it.pos_x) / CellDiv;
          row = int'(it.pos_y) / CellDiv;
          if (col >= 0 && col < MapDim && row >= 0 && row < MapDim) begin
            for (int dy = -1; dy <= 1; dy++) begin
              for (int dx = -1; dx <= 1; dx++) begin
                px = col + dx;
                py = row + dy;
                if (px >= 0 && px < MapDim && py >= 0 && py < MapDim)
                  map_model[py*MapDim + px] = it.profession;
              end
            end
          end
        end
      end
      CMD_READ: begin
        r.cell_value = map_model[int'(it.read_row)*MapDim + int'(it.read_col)];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Check results, then predict newly accepted commands
  always @(posedge clk_i) begin
    out_item_t exp_r;
    int col, row;
    if (rst_ni) begin
      if (map_valid && !map_stall) begin
        if (expected_cells.size() == 0) begin
          $error("result with no command outstanding: cell_value=%0d frame_done=%0d",
                 map_result.cell_value, map_result.frame_done);
          err_cnt++;
        end else begin
          exp_r = expected_cells.pop_front();
          if (map_result.cell_value !== exp_r.cell_value) begin
            $error("cell_value: expected %0d, got %0d", exp_r.cell_value,
                   map_result.cell_value);
            err_cnt++;
          end
          if (map_result.frame_done !== exp_r.frame_done) begin
            $error("frame_done: expected %0d, got %0d", exp_r.frame_done,
                   map_result.frame_done);
            err_cnt++;
          end
        end
      end
      if (agent_valid && !agent_stall) begin
        case (agent_item.command)
          CMD_CLEAR: n_clear++;
          CMD_PLOT: begin
            n_plot++;
            col = int'(agent_item.pos_x) / CellDiv;
            row = int'(agent_item.pos_y) / CellDiv;
            if (agent_item.active && int'(agent_item.pos_z) <= HeightMaxQ8 &&
                col >= 0 && col < MapDim && row >= 0 && row < MapDim)
              n_landed++;
          end
          CMD_READ: n_read++;
          default:  n_unused++;
        endcase
        expected_cells.push_back(splat_predict(agent_item));
      end
    end
  end

  // Receiver stall: switch between free, light and heavy stall stretches
  always @(posedge clk_i) begin
    int mode_left, stall_pct;
    if (mode_left == 0) begin
      mode_left = $urandom_range(5, 60);
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 30;
        default: stall_pct = 80;
      endcase
    end
    mode_left--;
    map_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((agent_valid && !agent_stall) || (map_valid && !map_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles", IdleLimit);
      $display("status: fail");
      $finish;
    end
  end

  // Send one command, with random bursts and gaps in front of it
  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 4);
        agent_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    agent_valid <= 1'b1;
    agent_item  <= it;
    @(posedge clk_i);
    while (agent_stall) @(posedge clk_i);
  endtask

  // Hold the sender until every owed result is back
  task automatic drain_results();
    agent_valid <= 1'b0;
    do @(posedge clk_i); while (expected_cells.size() != 0);
  endtask

  function automatic in_item_t mk_plot(input int x, input int y, input int z,
                                       input logic [7:0] prof, input logic act,
                                       input logic last);
    in_item_t it;
    it = '0;
    it.command       = CMD_PLOT;
    it.active        = act;
    it.pos_x         = 20'(x);
    it.pos_y         = 20'(y);
    it.pos_z         = 20'(z);
    it.profession    = prof;
    it.last_in_frame = last;
    return it;
  endfunction

  function automatic in_item_t mk_read(input int col, input int row);
    in_item_t it;
    it = '0;
    it.command  = CMD_READ;
    it.read_col = 8'(col);
    it.read_row = 8'(row);
    return it;
  endfunction

  function automatic in_item_t mk_clear();
    in_item_t it;
    it = '0;
    it.command = CMD_CLEAR;
    return it;
  endfunction

  // Map starts out zero after the clearing pass
  task automatic test_after_reset();
    send_item(mk_read(0, 0));
    send_item(mk_read(255, 255));
  endtask

  // Corners and the left edge, including a slightly negative x
  task automatic test_plot_edges();
    send_item(mk_plot(0, 0, 0, 8'hFF, 1'b1, 1'b1));
    send_item(mk_read(0, 0));
    send_item(mk_read(1, 1));
    send_item(mk_plot(255*CellDiv + 1023, 255*CellDiv + 1023, -524288, 8'h5A, 1'b1, 1'b0));
    send_item(mk_read(255, 255));
    send_item(mk_read(254, 254));
    send_item(mk_plot(-1023, 100*CellDiv, 0, 8'h81, 1'b1, 1'b0));
    send_item(mk_read(0, 100));
  endtask

  // Inactive agent, height limit on both sides, centers off the grid
  task automatic test_skips();
    send_item(mk_plot(10*CellDiv, 10*CellDiv, 0, 8'h11, 1'b0, 1'b1));
    send_item(mk_plot(20*CellDiv, 20*CellDiv, HeightMaxQ8 + 1, 8'h12, 1'b1, 1'b0));
    send_item(mk_plot(30*CellDiv, 30*CellDiv, HeightMaxQ8, 8'h22, 1'b1, 1'b0));
    send_item(mk_plot(-CellDiv, 40*CellDiv, 0, 8'h13, 1'b1, 1'b0));
    send_item(mk_plot(256*CellDiv, 40*CellDiv, 0, 8'h14, 1'b1, 1'b0));
    send_item(mk_plot(524287, -524288, 524287, 8'h15, 1'b1, 1'b1));
    send_item(mk_read(10, 10));
    send_item(mk_read(20, 20));
    send_item(mk_read(30, 30));
    send_item(mk_read(0, 40));
  endtask

  // A later plot overwrites the shared cells of an earlier one
  task automatic test_overwrite();
    send_item(mk_plot(50*CellDiv, 50*CellDiv, 0, 8'h33, 1'b1, 1'b0));
    send_item(mk_plot(51*CellDiv, 50*CellDiv, 0, 8'h44, 1'b1, 1'b0));
    send_item(mk_read(50, 50));
    send_item(mk_read(49, 50));
  endtask

  // Unused command returns zeros whatever else is set
  task automatic test_unused_command();
    in_item_t it;
    it = mk_plot(5*CellDiv, 5*CellDiv, 0, 8'hA5, 1'b1, 1'b1);
    it.command = CMD_NONE;
    send_item(it);
  endtask

  // Clear wipes what was plotted
  task automatic test_clear();
    send_item(mk_clear());
    send_item(mk_read(30, 30));
  endtask

  function automatic int pick_cell();
    logic [1:0] sel;
    sel = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) begin
      case (sel)
        2'd0:    return 0;
        2'd1:    return 1;
        2'd2:    return MapDim - 2;
        default: return MapDim - 1;
      endcase
    end
    return $urandom_range(0, MapDim - 1);
  endfunction

  // Plot that mostly lands on the grid, with random content
  function automatic in_item_t rand_plot();
    int col, row, x, y, z;
    col = pick_cell();
    row = pick_cell();
    x = col*CellDiv + $urandom_range(0, 1023);
    y = row*CellDiv + $urandom_range(0, 1023);
    if (col == 0 && $urandom_range(0, 1)) x = -$urandom_range(0, 1023);
    if (row == 0 && $urandom_range(0, 1)) y = -$urandom_range(0, 1023);
    z = $urandom_range(0, 80) - 40;
    if ($urandom_range(0, 9) == 0) z = $urandom();
    recent_centers.push_back({8'(row), 8'(col)});
    if (recent_centers.size() > 16) void'(recent_centers.pop_front());
    return mk_plot(x, y, z, 8'($urandom), ($urandom_range(0, 9) != 0),
                   ($urandom_range(0, 4) == 0));
  endfunction

  // Read close to a recent plot, or anywhere
  function automatic in_item_t rand_read();
    logic [15:0] ctr;
    if (recent_centers.size() == 0 || $urandom_range(0, 4) == 0)
      return mk_read($urandom_range(0, 255), $urandom_range(0, 255));
    ctr = recent_centers[$urandom_range(0, recent_centers.size() - 1)];
    return mk_read(int'(ctr[7:0]) + $urandom_range(0, 4) - 2,
                   int'(ctr[15:8]) + $urandom_range(0, 4) - 2);
  endfunction

  // Random bits in every field; clears are kept for fixed points
  function automatic in_item_t rand_noise();
    logic [95:0] raw;
    in_item_t it;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    if (it.command == CMD_CLEAR) it.command = CMD_READ;
    return it;
  endfunction

  task automatic test_random_traffic();
    int pick;
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems/3 || i == (2*RandomItems)/3) send_item(mk_clear());
      if (i == RandomItems/2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 45)      send_item(rand_plot());
      else if (pick < 82) send_item(rand_read());
      else                send_item(rand_noise());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_after_reset();
    test_plot_edges();
    test_skips();
    test_overwrite();
    test_unused_command();
    test_clear();
    test_random_traffic();
    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d plots (%0d on the grid), %0d reads, %0d clears, %0d unused",
             n_plot, n_landed, n_read, n_clear, n_unused);
    $display("mismatches: %0d", err_cnt);
    if (err_cnt == 0 && expected_cells.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
